// File: design/ismet_pkg.sv
package ismet_pkg;

  localparam int SITE_W     = 10;
  localparam int RAND_W     = 32;
  localparam int DE_W       = 5;
  localparam int MAG_W      = 12;
  localparam int ENERGY_W   = 13;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Request kinds carried on in_tuser.
  localparam logic REQ_LOAD = 1'b1;

  // Register indexes, taken from cfg_paddr[2].
  localparam logic REG_ACCEPT_FOUR  = 1'b0;
  localparam logic REG_ACCEPT_EIGHT = 1'b1;

  localparam logic [RAND_W-1:0] HALF_FRACTION = 32'h8000_0000;

  localparam logic [DE_W-1:0] DE_ZERO = 5'd0;
  localparam logic [DE_W-1:0] DE_FOUR = 5'd4;

  typedef struct packed {
    logic              req_type;
    logic [RAND_W-1:0] rand_value;
    logic              load_spin;
  } ismet_req_t;

  typedef struct packed {
    logic            flip;
    logic            spin_after;
    logic [DE_W-1:0] de;
  } ismet_eval_t;

endpackage

// File: design/ismet_cfg_regs.sv
module ismet_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ismet_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ismet_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ismet_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready,
  output logic [ismet_pkg::RAND_W-1:0]     level_four,
  output logic [ismet_pkg::RAND_W-1:0]     level_eight
);

  logic [ismet_pkg::RAND_W-1:0] level_four_r;
  logic [ismet_pkg::RAND_W-1:0] level_eight_r;
  logic                         wr_strobe;

  assign pready    = 1'b1;
  assign wr_strobe = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_four_r  <= '0;
      level_eight_r <= '0;
    end else if (wr_strobe) begin
      if (paddr[2] == ismet_pkg::REG_ACCEPT_EIGHT) begin
        level_eight_r <= pwdata;
      end else begin
        level_four_r <= pwdata;
      end
    end
  end

  assign prdata      = (paddr[2] == ismet_pkg::REG_ACCEPT_FOUR) ? level_four_r : level_eight_r;
  assign level_four  = level_four_r;
  assign level_eight = level_eight_r;

endmodule

// File: design/ismet_lattice_mem.sv
module ismet_lattice_mem #(
  parameter int SIDE = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    rd_en_a,
  input  logic [$clog2(SIDE)-1:0] rd_addr_a,
  output logic [SIDE-1:0]         rd_data_a,
  input  logic                    rd_en_b,
  input  logic [$clog2(SIDE)-1:0] rd_addr_b,
  output logic [SIDE-1:0]         rd_data_b,
  input  logic                    wr_en,
  input  logic [$clog2(SIDE)-1:0] wr_addr,
  input  logic [SIDE-1:0]         wr_data
);

  // One word per lattice row. A row never written since reset reads as all +1.
  logic [SIDE-1:0] mem_r [SIDE];
  logic [SIDE-1:0] row_valid_r;
  logic [SIDE-1:0] q_a_r;
  logic [SIDE-1:0] q_b_r;
  logic            vld_a_r;
  logic            vld_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en_a) begin
      q_a_r <= mem_r[rd_addr_a];
    end
    if (rd_en_b) begin
      q_b_r <= mem_r[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      vld_a_r     <= 1'b0;
      vld_b_r     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en_a) begin
        vld_a_r <= row_valid_r[rd_addr_a];
      end
      if (rd_en_b) begin
        vld_b_r <= row_valid_r[rd_addr_b];
      end
    end
  end

  assign rd_data_a = vld_a_r ? q_a_r : '1;
  assign rd_data_b = vld_b_r ? q_b_r : '1;

endmodule

// File: design/ismet_site_eval.sv
module ismet_site_eval #(
  parameter int SIDE = 32
) (
  input  logic [SIDE-1:0]              cur_row,
  input  logic [SIDE-1:0]              up_row,
  input  logic [SIDE-1:0]              down_row,
  input  logic [$clog2(SIDE)-1:0]      col,
  input  ismet_pkg::ismet_req_t        req,
  input  logic [ismet_pkg::RAND_W-1:0] level_four,
  input  logic [ismet_pkg::RAND_W-1:0] level_eight,
  output ismet_pkg::ismet_eval_t       result
);

  localparam int CW = $clog2(SIDE);

  logic [CW-1:0]              col_left;
  logic [CW-1:0]              col_right;
  logic                       center;
  logic [2:0]                 n_up;
  logic [ismet_pkg::DE_W-1:0] base;
  logic [ismet_pkg::DE_W-1:0] de;
  logic                       accept;

  assign col_left  = (col == '0) ? CW'(SIDE - 1) : col - CW'(1);
  assign col_right = (col == CW'(SIDE - 1)) ? '0 : col + CW'(1);
  assign center    = cur_row[col];

  assign n_up = 3'(cur_row[col_left]) + 3'(cur_row[col_right])
              + 3'(up_row[col]) + 3'(down_row[col]);

  // Neighbor sum is 2*n_up - 4, so the flip energy is s * (4*n_up - 8).
  assign base = ismet_pkg::DE_W'({n_up, 2'b00}) - ismet_pkg::DE_W'(8);
  assign de   = center ? base : ismet_pkg::DE_W'(0) - base;

  always_comb begin
    if (req.req_type == ismet_pkg::REQ_LOAD) begin
      accept = (req.load_spin != center);
    end else if (de[ismet_pkg::DE_W-1]) begin
      accept = 1'b1;
    end else if (de == ismet_pkg::DE_ZERO) begin
      accept = req.rand_value < ismet_pkg::HALF_FRACTION;
    end else if (de == ismet_pkg::DE_FOUR) begin
      accept = req.rand_value < level_four;
    end else begin
      accept = req.rand_value < level_eight;
    end
  end

  assign result.flip       = accept;
  assign result.spin_after = center ^ accept;
  assign result.de         = accept ? de : ismet_pkg::DE_ZERO;

endmodule

// File: design/ising_metropolis_site_update_core.sv
// An accepted request passes the states RD1, RD2 and EVAL; the result beat is
// registered on commit. A new item is taken only in the idle state. The three lattice
// rows around the site are read through the two read ports of the row memory, and
// a flip writes the site's row back. Reset (rst_n, synchronous, active low): lattice
// reads as all +1 through per-row valid flags with no clearing pass, magnetization is
// SIDE*SIDE, energy is -2*SIDE*SIDE and both acceptance thresholds are zero.
module ising_metropolis_site_update_core #(
  parameter int SIDE = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: site [9:0], rand_value [41:10], load_spin [42], zero fill [47:43]
  input  logic [ismet_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: req_type [0]
  input  logic                                in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata: flipped [0], spin_now [1], energy_change [6:2], magnetization [18:7],
  // total_energy [31:19]
  output logic [ismet_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ismet_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ismet_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ismet_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);

  localparam int RW = $clog2(SIDE);
  localparam int CW = $clog2(SIDE);
  localparam int RECIP_SHIFT = 20;
  // Rounded-up reciprocal; exact quotient for every 10-bit site up to SIDE = 128.
  localparam int unsigned RECIP = ((1 << RECIP_SHIFT) + SIDE - 1) / SIDE;
  localparam logic [14:0] NSITES_V = 15'(SIDE * SIDE);
  localparam logic [ismet_pkg::MAG_W-1:0]    MAG_RESET    = ismet_pkg::MAG_W'(SIDE * SIDE);
  localparam logic [ismet_pkg::ENERGY_W-1:0] ENERGY_RESET =
    ismet_pkg::ENERGY_W'(-2 * SIDE * SIDE);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD1  = 2'd1;
  localparam logic [1:0] ST_RD2  = 2'd2;
  localparam logic [1:0] ST_EVAL = 2'd3;

  logic [1:0]                       state_r;
  logic [1:0]                       state_nxt;
  ismet_pkg::ismet_req_t            req_r;
  logic [ismet_pkg::SITE_W-1:0]     site_r;
  logic [RW-1:0]                    row_r;
  logic [CW-1:0]                    col_r;
  logic                             in_range_r;
  logic [SIDE-1:0]                  cur_row_r;
  logic [SIDE-1:0]                  up_row_r;
  logic                             out_tvalid_r;
  logic                             out_flip_r;
  logic                             out_spin_r;
  logic [ismet_pkg::DE_W-1:0]       out_de_r;
  logic [ismet_pkg::MAG_W-1:0]      mag_r;
  logic [ismet_pkg::ENERGY_W-1:0]   energy_r;

  logic [ismet_pkg::SITE_W-1:0]     in_site;
  logic [28:0]                      row_prod;
  logic [10:0]                      col_wide;
  logic [RW-1:0]                    row_up;
  logic [RW-1:0]                    row_down;
  logic                             in_beat;
  logic                             can_load;
  logic                             commit;
  logic                             rd_en_a;
  logic                             rd_en_b;
  logic [RW-1:0]                    rd_addr_a;
  logic [SIDE-1:0]                  rd_data_a;
  logic [SIDE-1:0]                  rd_data_b;
  logic                             wr_en;
  logic [SIDE-1:0]                  wr_data;
  logic [ismet_pkg::RAND_W-1:0]     level_four;
  logic [ismet_pkg::RAND_W-1:0]     level_eight;
  ismet_pkg::ismet_eval_t           eval_res;

  ismet_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .level_four  (level_four),
    .level_eight (level_eight)
  );

  assign in_site   = in_tdata[ismet_pkg::SITE_W-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign row_prod  = {19'd0, in_site} * 29'(RECIP);

  assign row_up   = (row_r == '0) ? RW'(SIDE - 1) : row_r - RW'(1);
  assign row_down = (row_r == RW'(SIDE - 1)) ? '0 : row_r + RW'(1);
  assign col_wide = {1'b0, site_r} - 11'(row_r * SIDE);

  assign can_load = !out_tvalid_r || out_tready;
  assign commit   = (state_r == ST_EVAL) && can_load;

  // Port A reads the site's row, then the row below; port B reads the row above.
  assign rd_en_a   = (state_r == ST_RD1) || (state_r == ST_RD2);
  assign rd_addr_a = (state_r == ST_RD1) ? row_r : row_down;
  assign rd_en_b   = (state_r == ST_RD1);
  assign wr_en     = commit && in_range_r && eval_res.flip;
  assign wr_data   = cur_row_r ^ ({{(SIDE-1){1'b0}}, 1'b1} << col_r);

  ismet_lattice_mem #(
    .SIDE (SIDE)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en_a   (rd_en_a),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_en_b   (rd_en_b),
    .rd_addr_b (row_up),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (row_r),
    .wr_data   (wr_data)
  );

  // In the evaluation state port A holds the row below the site.
  ismet_site_eval #(
    .SIDE (SIDE)
  ) u_eval (
    .cur_row     (cur_row_r),
    .up_row      (up_row_r),
    .down_row    (rd_data_a),
    .col         (col_r),
    .req         (req_r),
    .level_four  (level_four),
    .level_eight (level_eight),
    .result      (eval_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = ST_RD1;
        end
      end
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      mag_r        <= MAG_RESET;
      energy_r     <= ENERGY_RESET;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (wr_en) begin
        energy_r <= energy_r
                  + {{(ismet_pkg::ENERGY_W-ismet_pkg::DE_W){eval_res.de[ismet_pkg::DE_W-1]}},
                     eval_res.de};
        // A +1 spin going to -1 lowers the sum by two, and the reverse raises it.
        if (eval_res.spin_after) begin
          mag_r <= mag_r + ismet_pkg::MAG_W'(2);
        end else begin
          mag_r <= mag_r - ismet_pkg::MAG_W'(2);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      site_r           <= in_site;
      req_r.req_type   <= in_tuser;
      req_r.rand_value <= in_tdata[ismet_pkg::SITE_W +: ismet_pkg::RAND_W];
      req_r.load_spin  <= in_tdata[ismet_pkg::SITE_W + ismet_pkg::RAND_W];
      row_r            <= row_prod[RECIP_SHIFT +: RW];
      in_range_r       <= {5'd0, in_site} < NSITES_V;
    end
    if (state_r == ST_RD1) begin
      col_r <= col_wide[CW-1:0];
    end
    if (state_r == ST_RD2) begin
      cur_row_r <= rd_data_a;
      up_row_r  <= rd_data_b;
    end
    if (commit) begin
      out_flip_r <= in_range_r && eval_res.flip;
      out_spin_r <= in_range_r && eval_res.spin_after;
      out_de_r   <= in_range_r ? eval_res.de : ismet_pkg::DE_ZERO;
    end
  end

  // The totals change only on a commit, which needs the output slot free, so they
  // hold steady while a result beat waits.
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {energy_r, mag_r, out_de_r, out_spin_r, out_flip_r};

endmodule

// File: bench/tb_ising_metropolis_site_update_core.sv
`timescale 1ns / 100ps

module tb_ising_metropolis_site_update_core;

  localparam int SIDE = 32;
  localparam int NSITES = SIDE * SIDE;
  localparam int SINK_HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  localparam logic REQ_UPDATE = ~ismet_pkg::REQ_LOAD;
  localparam logic [ismet_pkg::CFG_ADDR_W-1:0] ADDR_FOUR = {ismet_pkg::REG_ACCEPT_FOUR, 2'b00};
  localparam logic [ismet_pkg::CFG_ADDR_W-1:0] ADDR_EIGHT =
    {ismet_pkg::REG_ACCEPT_EIGHT, 2'b00};
  localparam logic [ismet_pkg::RAND_W-1:0] FRACTION_MAX = '1;

  typedef struct {
    bit flipped;
    bit spin_now;
    int de;
    int mag;
    int energy;
  } site_outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [ismet_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ismet_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ismet_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [ismet_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [ismet_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // Shadow of the block: spins (1 = +1), running totals and thresholds.
  bit lattice_spin [NSITES];
  int mag_total;
  int energy_total;
  logic [ismet_pkg::RAND_W-1:0] level_four;
  logic [ismet_pkg::RAND_W-1:0] level_eight;

  site_outcome_t site_outcomes_q[$];
  site_outcome_t head_outcome;
  int mismatches = 0;
  int cycle_count = 0;
  bit feed_gaps = 1'b0;
  bit drain_stalls = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;

  ising_metropolis_site_update_core #(.SIDE(SIDE)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ising_metropolis_site_update_core: mismatch");
      $finish;
    end
  end

  function automatic int spin_at(int idx);
    return lattice_spin[idx] ? 1 : -1;
  endfunction

  function automatic site_outcome_t metropolis_predict(logic req,
                                                       logic [ismet_pkg::SITE_W-1:0] site,
                                                       logic [ismet_pkg::RAND_W-1:0] rnd,
                                                       logic ld);
    site_outcome_t o;
    int idx, row, col, s, nsum, d;
    bit flip;
    idx = int'(site);
    flip = 1'b0;
    o.de = 0;
    o.spin_now = 1'b0;
    if (idx < NSITES) begin
      row = idx / SIDE;
      col = idx % SIDE;
      s = spin_at(idx);
      nsum = spin_at(row * SIDE + (col + 1) % SIDE)
           + spin_at(row * SIDE + (col + SIDE - 1) % SIDE)
           + spin_at(((row + SIDE - 1) % SIDE) * SIDE + col)
           + spin_at(((row + 1) % SIDE) * SIDE + col);
      d = 2 * s * nsum;
      if (req == ismet_pkg::REQ_LOAD) flip = (ld != lattice_spin[idx]);
      else if (d < 0) flip = 1'b1;
      else if (d == 0) flip = rnd < ismet_pkg::HALF_FRACTION;
      else if (d == 4) flip = rnd < level_four;
      else flip = rnd < level_eight;
      if (flip) begin
        lattice_spin[idx] = ~lattice_spin[idx];
        mag_total -= 2 * s;
        energy_total += d;
        o.de = d;
      end
      o.spin_now = lattice_spin[idx];
    end
    o.flipped = flip;
    o.mag = mag_total;
    o.energy = energy_total;
    return o;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (site_outcomes_q.size() == 0) begin
        $error("result beat with nothing expected: out_tdata %h", out_tdata);
        mismatches++;
      end else begin
        head_outcome = site_outcomes_q.pop_front();
        check_field("flipped", int'(head_outcome.flipped), int'(out_tdata[0]));
        check_field("spin_now", int'(head_outcome.spin_now), int'(out_tdata[1]));
        check_field("energy_change", head_outcome.de, int'($signed(out_tdata[6:2])));
        check_field("magnetization", head_outcome.mag, int'($signed(out_tdata[18:7])));
        check_field("total_energy", head_outcome.energy, int'($signed(out_tdata[31:19])));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        out_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      out_tready <= !(drain_stalls && $urandom_range(99) < 33);
    end
  end

  task automatic send_item(input logic req, input logic [ismet_pkg::SITE_W-1:0] site,
                           input logic [ismet_pkg::RAND_W-1:0] rnd, input logic ld);
    while (feed_gaps && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {5'b0, ld, rnd, site};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    site_outcomes_q.insert(site_outcomes_q.size(), metropolis_predict(req, site, rnd, ld));
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (site_outcomes_q.size() != 0);
  endtask

  task automatic cfg_access(input logic wr, input logic [ismet_pkg::CFG_ADDR_W-1:0] addr,
                            input logic [ismet_pkg::CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (!wr && cfg_prdata !== data) begin
      $error("register at %0d: expected %h, got %h", addr, data, cfg_prdata);
      mismatches++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Called only with the block idle; both registers are written and read back.
  task automatic set_thresholds(input logic [ismet_pkg::RAND_W-1:0] four,
                                input logic [ismet_pkg::RAND_W-1:0] eight);
    wait_drain();
    cfg_access(1'b1, ADDR_FOUR, four);
    level_four = four;
    cfg_access(1'b1, ADDR_EIGHT, eight);
    level_eight = eight;
    cfg_access(1'b0, ADDR_FOUR, four);
    cfg_access(1'b0, ADDR_EIGHT, eight);
  endtask

  function automatic logic [ismet_pkg::RAND_W-1:0] pick_fraction();
    case ($urandom_range(9))
      0: return '0;
      1: return FRACTION_MAX;
      2: return ismet_pkg::HALF_FRACTION + $urandom_range(2) - 1;
      3: return level_four + $urandom_range(2) - 1;
      4: return level_eight + $urandom_range(2) - 1;
      default: return $urandom;
    endcase
  endfunction

  // Sites cluster on the wrapped corner and a small inner patch so that
  // neighbours interact; the rest spread over the whole lattice.
  function automatic logic [ismet_pkg::SITE_W-1:0] pick_site();
    int row, col;
    case ($urandom_range(3))
      0, 1: begin
        row = (30 + $urandom_range(3)) % SIDE;
        col = (30 + $urandom_range(3)) % SIDE;
      end
      2: begin
        row = $urandom_range(12, 10);
        col = $urandom_range(12, 10);
      end
      default: begin
        row = $urandom_range(SIDE - 1);
        col = $urandom_range(SIDE - 1);
      end
    endcase
    return ismet_pkg::SITE_W'(row * SIDE + col);
  endfunction

  task automatic random_items(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 30)
        send_item(ismet_pkg::REQ_LOAD, pick_site(), $urandom, 1'($urandom_range(1)));
      else
        send_item(REQ_UPDATE, pick_site(), pick_fraction(), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_directed();
    feed_gaps = 1'b1;
    drain_stalls = 1'b1;
    // Thresholds are zero after reset: a rise of eight or four is refused.
    send_item(REQ_UPDATE, 10'd0, 32'h0, 1'b0);
    send_item(ismet_pkg::REQ_LOAD, 10'd0, FRACTION_MAX, 1'b1);
    send_item(ismet_pkg::REQ_LOAD, 10'd0, 32'h0, 1'b0);
    send_item(REQ_UPDATE, 10'd1, 32'h0, 1'b1);
    send_item(REQ_UPDATE, 10'd0, FRACTION_MAX, 1'b0);
    // Site 33 with two opposed neighbours sees no energy change.
    send_item(ismet_pkg::REQ_LOAD, 10'd32, 32'h0, 1'b0);
    send_item(ismet_pkg::REQ_LOAD, 10'd34, 32'h0, 1'b0);
    send_item(REQ_UPDATE, 10'd33, ismet_pkg::HALF_FRACTION, 1'b0);
    send_item(REQ_UPDATE, 10'd33, ismet_pkg::HALF_FRACTION - 1, 1'b0);
    send_item(ismet_pkg::REQ_LOAD, 10'd33, 32'h0, 1'b1);
    // A third opposed neighbour makes the flip an energy drop of four.
    send_item(ismet_pkg::REQ_LOAD, 10'd1, 32'h0, 1'b0);
    send_item(REQ_UPDATE, 10'd33, FRACTION_MAX, 1'b1);
    set_thresholds(FRACTION_MAX, FRACTION_MAX);
    send_item(REQ_UPDATE, 10'd1023, FRACTION_MAX - 1, 1'b0);
    send_item(REQ_UPDATE, 10'd1023, FRACTION_MAX, 1'b1);
    send_item(REQ_UPDATE, 10'd31, FRACTION_MAX, 1'b0);
    send_item(ismet_pkg::REQ_LOAD, 10'd1, 32'h0, 1'b1);
    send_item(ismet_pkg::REQ_LOAD, 10'd33, 32'h0, 1'b0);
    send_item(REQ_UPDATE, 10'd1, FRACTION_MAX - 1, 1'b0);
    send_item(REQ_UPDATE, 10'd992, 32'h0, 1'b0);
    send_item(ismet_pkg::REQ_LOAD, 10'd992, FRACTION_MAX, 1'b1);
    send_item(ismet_pkg::REQ_LOAD, 10'd1023, 32'h5555_5555, 1'b0);
  endtask

  task automatic test_random_mid_thresholds();
    set_thresholds($urandom_range(32'h7FFF_FFFF), $urandom_range(32'h3FFF_FFFF));
    feed_gaps = 1'b1;
    drain_stalls = 1'b1;
    random_items(300);
  endtask

  // Hot lattice with both sides running flat out.
  task automatic test_full_rate_hot();
    set_thresholds(FRACTION_MAX, FRACTION_MAX);
    feed_gaps = 1'b0;
    drain_stalls = 1'b0;
    random_items(250);
  endtask

  task automatic test_zero_temperature();
    set_thresholds('0, '0);
    feed_gaps = 1'b1;
    drain_stalls = 1'b1;
    random_items(200);
  endtask

  task automatic test_uneven_thresholds();
    set_thresholds(FRACTION_MAX, '0);
    random_items(100);
    set_thresholds($urandom, $urandom);
    random_items(250);
  endtask

  // The receiver holds off while items keep coming, so the input side stalls.
  task automatic test_output_backpressure();
    set_thresholds(ismet_pkg::HALF_FRACTION, 32'h2000_0000);
    feed_gaps = 1'b0;
    drain_stalls = 1'b1;
    hold_requests++;
    random_items(40);
    feed_gaps = 1'b1;
    random_items(100);
  endtask

  initial begin
    for (int i = 0; i < NSITES; i++) lattice_spin[i] = 1'b1;
    mag_total = NSITES;
    energy_total = -2 * NSITES;
    level_four = '0;
    level_eight = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mid_thresholds();
    test_full_rate_hot();
    test_zero_temperature();
    test_uneven_thresholds();
    test_output_backpressure();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ising_metropolis_site_update_core: match");
    else
      $display("ising_metropolis_site_update_core: mismatch");
    $finish;
  end

endmodule
